@@ hw/rtl/ffa_pkg.sv @@
// Package for the first-fit named heap allocator.
// Holds sizes, status codes, cell structs and the controller state type.
// No dependencies.
package ffa_pkg;

    localparam int HEAP_BYTES    = 512;
    localparam int FREE_ENTRIES  = 16;
    localparam int BLOCK_ENTRIES = 16;

    localparam int ADDR_W  = 9;
    localparam int LEN_W   = 10;
    localparam int KEY_W   = 64;
    localparam int FIDX_W  = $clog2(FREE_ENTRIES);
    localparam int BIDX_W  = $clog2(BLOCK_ENTRIES);
    localparam int FCNT_W  = $clog2(FREE_ENTRIES + 1);
    localparam int BCNT_W  = $clog2(BLOCK_ENTRIES + 1);

    localparam logic [LEN_W-1:0] HEADER_BYTES  = 10'd4;
    localparam logic [LEN_W-1:0] INIT_TOP      = 10'd100;
    localparam logic [LEN_W-1:0] RESET_CEILING = 10'd300;
    localparam logic [LEN_W:0]   HEAP_LIMIT    = 11'(HEAP_BYTES);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_HEAP_FULL = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_TABLE_FULL = 2'd3
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  length;
    } free_entry_t;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  name;
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  length;
    } block_entry_t;

    // Commands broadcast to every cell of a chain
    typedef enum logic [2:0] {
        FC_HOLD,
        FC_INSERT,   // open slot at pos, write new entry
        FC_REMOVE,   // close slot at pos
        FC_WRITE     // overwrite entry at pos
    } fcmd_t;

    typedef struct packed {
        fcmd_t             cmd;
        logic [FIDX_W-1:0] pos;
        free_entry_t       data;
    } free_ctl_t;

    typedef struct packed {
        logic              append;
        logic              remove;
        logic [BIDX_W-1:0] pos;
        block_entry_t      data;
    } block_ctl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FSCAN,     // walk free table
        S_GROW,      // drop right neighbor after a merge
        S_CARVE,
        S_BSCAN,     // walk block table for name
        S_FINS,      // find free insert point
        S_FMERGE,
        S_BDEL,
        S_DONE
    } state_t;

endpackage

@@ hw/rtl/first_fit_named_heap_allocator_unit.sv @@
// First-fit named heap allocator, top level: two cell chains and a scan sequencer.
// Scans walk one entry a cycle; a free walks the block chain then the free chain,
// an alloc scans the free chain twice at most, with an insert walk between the scans.
// One transaction at a time: s_ready stays low until the result has been taken on
// m_ready, so a new request is not accepted while another is in flight.
// Reset (aresetn, synchronous): free chain holds region (0,100), block chain empty,
// heap top 100, ceiling 300. Depends on ffa_pkg, ffa_free_cell, ffa_block_cell.
module first_fit_named_heap_allocator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [63:0] s_buffer_key,
    input  logic [8:0]  s_payload_bytes,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [8:0]  m_block_address,
    output logic [9:0]  m_block_bytes
);
    localparam int FN = ffa_pkg::FREE_ENTRIES;
    localparam int BN = ffa_pkg::BLOCK_ENTRIES;
    localparam int AW = ffa_pkg::ADDR_W;
    localparam int LW = ffa_pkg::LEN_W;

    ffa_pkg::free_entry_t  fent [FN];
    ffa_pkg::block_entry_t bent [BN];
    ffa_pkg::free_ctl_t    fctl;
    ffa_pkg::block_ctl_t   bctl;

    genvar g;
    generate
        for (g = 0; g < FN; g++) begin : g_free
            ffa_pkg::free_entry_t lin, rin, rv;
            assign lin = (g == 0) ? '0 : fent[(g == 0) ? 0 : g-1];
            assign rin = (g == FN-1) ? '0 : fent[(g == FN-1) ? g : g+1];
            assign rv  = (g == 0) ? '{valid: 1'b1, start: '0, length: ffa_pkg::INIT_TOP}
                                  : '0;
            ffa_free_cell u_cell (
                .aclk(aclk), .aresetn(aresetn), .idx(ffa_pkg::FIDX_W'(g)),
                .reset_val(rv), .ctl(fctl), .left_in(lin), .right_in(rin),
                .entry(fent[g])
            );
        end
        for (g = 0; g < BN; g++) begin : g_blk
            ffa_pkg::block_entry_t rin;
            assign rin = (g == BN-1) ? '0 : bent[(g == BN-1) ? g : g+1];
            ffa_block_cell u_cell (
                .aclk(aclk), .aresetn(aresetn), .idx(ffa_pkg::BIDX_W'(g)),
                .ctl(bctl), .right_in(rin), .entry(bent[g])
            );
        end
    endgenerate

    ffa_pkg::state_t state_reg, state_next;
    logic [LW-1:0]   ceil_reg;
    logic [LW-1:0]   top_reg, top_next;
    logic            op_reg;
    logic [63:0]     key_reg;
    logic [LW-1:0]   req_reg;
    logic [ffa_pkg::FCNT_W-1:0] fi_reg, fi_next;
    logic [ffa_pkg::BCNT_W-1:0] bi_reg, bi_next;
    logic            grown_reg, grown_next;
    logic [AW-1:0]   ins_s_reg, ins_s_next;
    logic [LW-1:0]   ins_l_reg, ins_l_next;
    logic [ffa_pkg::BIDX_W-1:0] bhit_reg, bhit_next;
    logic            ovalid_reg, ovalid_next;
    logic [1:0]      ost_reg, ost_next;
    logic [AW-1:0]   oaddr_reg, oaddr_next;
    logic [LW-1:0]   obytes_reg, obytes_next;

    logic [LW-1:0]   ceil_eff;
    logic [ffa_pkg::FCNT_W-1:0] fcount;
    logic [ffa_pkg::BCNT_W-1:0] bcount;
    ffa_pkg::free_entry_t cur, prv;
    ffa_pkg::block_entry_t bcur;
    logic [ffa_pkg::FIDX_W-1:0] fpos;
    logic            left_adj, right_adj;
    logic [LW:0]     sum_top;

    assign ceil_eff = ({1'b0, ceil_reg} < ffa_pkg::HEAP_LIMIT) ? ceil_reg : LW'(ffa_pkg::HEAP_BYTES);

    // packed valid bits give the counts
    always_comb begin
        fcount = '0;
        for (int i = 0; i < FN; i++) fcount = fcount + ffa_pkg::FCNT_W'(fent[i].valid);
        bcount = '0;
        for (int i = 0; i < BN; i++) bcount = bcount + ffa_pkg::BCNT_W'(bent[i].valid);
    end

    assign fpos = fi_reg[ffa_pkg::FIDX_W-1:0];
    assign cur  = (fi_reg < ffa_pkg::FCNT_W'(FN)) ? fent[fpos] : '0;
    assign prv  = (fi_reg != '0) ? fent[ffa_pkg::FIDX_W'(fi_reg - 1'b1)] : '0;
    assign bcur = (bi_reg < ffa_pkg::BCNT_W'(BN)) ? bent[bi_reg[ffa_pkg::BIDX_W-1:0]] : '0;
    assign left_adj  = (fi_reg != '0) &&
                       ((LW'(prv.start) + prv.length) == LW'(ins_s_reg));
    assign right_adj = (fi_reg < fcount) && ((LW'(ins_s_reg) + ins_l_reg) == LW'(cur.start));
    assign sum_top = {1'b0, top_reg} + {1'b0, req_reg};

    assign s_ready = (state_reg == ffa_pkg::S_IDLE) && !ovalid_reg;

    always_comb begin
        state_next  = state_reg;
        top_next    = top_reg;
        fi_next     = fi_reg;
        bi_next     = bi_reg;
        grown_next  = grown_reg;
        ins_s_next  = ins_s_reg;
        ins_l_next  = ins_l_reg;
        bhit_next   = bhit_reg;
        ovalid_next = ovalid_reg && !m_ready;
        ost_next    = ost_reg;
        oaddr_next  = oaddr_reg;
        obytes_next = obytes_reg;
        fctl = '{cmd: ffa_pkg::FC_HOLD, pos: '0, data: '0};
        bctl = '{append: 1'b0, remove: 1'b0, pos: '0, data: '0};

        unique case (state_reg)
            ffa_pkg::S_IDLE: begin
                if (s_valid && s_ready) begin
                    fi_next = '0;
                    bi_next = '0;
                    grown_next = 1'b0;
                    if (s_opcode == ffa_pkg::OP_ALLOC) begin
                        if (top_reg >= ceil_eff) begin
                            ost_next = ffa_pkg::ST_HEAP_FULL;
                            state_next = ffa_pkg::S_DONE;
                        end else if (bcount >= ffa_pkg::BCNT_W'(BN)) begin
                            ost_next = ffa_pkg::ST_TABLE_FULL;
                            state_next = ffa_pkg::S_DONE;
                        end else begin
                            state_next = ffa_pkg::S_FSCAN;
                        end
                    end else begin
                        state_next = ffa_pkg::S_BSCAN;
                    end
                end
            end
            ffa_pkg::S_FSCAN: begin
                if (fi_reg >= fcount) begin
                    if (grown_reg) begin
                        ost_next = ffa_pkg::ST_HEAP_FULL;
                        state_next = ffa_pkg::S_DONE;
                    end else if (sum_top >= {1'b0, ceil_eff}) begin
                        ost_next = ffa_pkg::ST_HEAP_FULL;
                        state_next = ffa_pkg::S_DONE;
                    end else begin
                        ins_s_next = top_reg[AW-1:0];
                        ins_l_next = req_reg;
                        fi_next = '0;
                        state_next = ffa_pkg::S_FINS;
                    end
                end else if (cur.length >= req_reg) begin
                    state_next = ffa_pkg::S_CARVE;
                end else begin
                    fi_next = fi_reg + 1'b1;
                end
            end
            ffa_pkg::S_CARVE: begin
                ost_next = ffa_pkg::ST_OK;
                oaddr_next = cur.start;
                obytes_next = req_reg;
                if (cur.length == req_reg) begin
                    fctl.cmd = ffa_pkg::FC_REMOVE;
                    fctl.pos = fpos;
                end else begin
                    fctl.cmd = ffa_pkg::FC_WRITE;
                    fctl.pos = fpos;
                    fctl.data = '{valid: 1'b1, start: AW'(LW'(cur.start) + req_reg),
                                  length: cur.length - req_reg};
                end
                bctl.append = 1'b1;
                bctl.pos = bcount[ffa_pkg::BIDX_W-1:0];
                bctl.data = '{valid: 1'b1, name: key_reg, start: cur.start, length: req_reg};
                state_next = ffa_pkg::S_DONE;
            end
            ffa_pkg::S_BSCAN: begin
                if (bi_reg >= bcount) begin
                    ost_next = ffa_pkg::ST_NOT_FOUND;
                    state_next = ffa_pkg::S_DONE;
                end else if (bcur.name == key_reg) begin
                    bhit_next = bi_reg[ffa_pkg::BIDX_W-1:0];
                    ins_s_next = bcur.start;
                    ins_l_next = bcur.length;
                    fi_next = '0;
                    state_next = ffa_pkg::S_FINS;
                end else begin
                    bi_next = bi_reg + 1'b1;
                end
            end
            ffa_pkg::S_FINS: begin
                // advance to first entry with start > s
                if (fi_reg < fcount && cur.start <= ins_s_reg) fi_next = fi_reg + 1'b1;
                else state_next = ffa_pkg::S_FMERGE;
            end
            ffa_pkg::S_FMERGE: begin
                if (left_adj && right_adj) begin
                    fctl.cmd = ffa_pkg::FC_WRITE;
                    fctl.pos = ffa_pkg::FIDX_W'(fi_reg - 1'b1);
                    fctl.data = '{valid: 1'b1, start: prv.start,
                                  length: prv.length + ins_l_reg + cur.length};
                    state_next = ffa_pkg::S_GROW;
                end else if (left_adj) begin
                    fctl.cmd = ffa_pkg::FC_WRITE;
                    fctl.pos = ffa_pkg::FIDX_W'(fi_reg - 1'b1);
                    fctl.data = '{valid: 1'b1, start: prv.start, length: prv.length + ins_l_reg};
                    state_next = ffa_pkg::S_BDEL;
                end else if (right_adj) begin
                    fctl.cmd = ffa_pkg::FC_WRITE;
                    fctl.pos = fpos;
                    fctl.data = '{valid: 1'b1, start: ins_s_reg, length: cur.length + ins_l_reg};
                    state_next = ffa_pkg::S_BDEL;
                end else if (fcount >= ffa_pkg::FCNT_W'(FN)) begin
                    ost_next = ffa_pkg::ST_TABLE_FULL;
                    state_next = ffa_pkg::S_DONE;
                end else begin
                    fctl.cmd = ffa_pkg::FC_INSERT;
                    fctl.pos = fpos;
                    fctl.data = '{valid: 1'b1, start: ins_s_reg, length: ins_l_reg};
                    state_next = ffa_pkg::S_BDEL;
                end
            end
            ffa_pkg::S_GROW: begin
                // drop the right neighbor absorbed by the merge
                fctl.cmd = ffa_pkg::FC_REMOVE;
                fctl.pos = fpos;
                state_next = ffa_pkg::S_BDEL;
            end
            ffa_pkg::S_BDEL: begin
                if (op_reg == ffa_pkg::OP_ALLOC) begin
                    top_next = LW'(sum_top);
                    grown_next = 1'b1;
                    fi_next = '0;
                    state_next = ffa_pkg::S_FSCAN;
                end else begin
                    bctl.remove = 1'b1;
                    bctl.pos = bhit_reg;
                    ost_next = ffa_pkg::ST_OK;
                    oaddr_next = ins_s_reg;
                    obytes_next = ins_l_reg;
                    state_next = ffa_pkg::S_DONE;
                end
            end
            ffa_pkg::S_DONE: begin
                if (ost_next != ffa_pkg::ST_OK) begin
                    oaddr_next = '0;
                    obytes_next = '0;
                end
                ovalid_next = 1'b1;
                state_next = ffa_pkg::S_IDLE;
            end
            default: state_next = ffa_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ffa_pkg::S_IDLE;
            ceil_reg   <= ffa_pkg::RESET_CEILING;
            top_reg    <= ffa_pkg::INIT_TOP;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            if (cfg_we) ceil_reg <= cfg_wdata;
            top_reg    <= top_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= s_opcode;
            key_reg <= s_buffer_key;
            req_reg <= {1'b0, s_payload_bytes} + ffa_pkg::HEADER_BYTES;
        end
        fi_reg     <= fi_next;
        bi_reg     <= bi_next;
        grown_reg  <= grown_next;
        ins_s_reg  <= ins_s_next;
        ins_l_reg  <= ins_l_next;
        bhit_reg   <= bhit_next;
        ost_reg    <= ost_next;
        oaddr_reg  <= oaddr_next;
        obytes_reg <= obytes_next;
    end

    assign m_valid         = ovalid_reg;
    assign m_status        = ost_reg;
    assign m_block_address = oaddr_reg;
    assign m_block_bytes   = obytes_reg;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ffa_pkg::S_IDLE) |-> !s_ready)
        else $error("input taken while busy");
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status)))
        else $error("result dropped");
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ffa_pkg::ST_OK) |-> (m_block_bytes == '0))
        else $error("failed result carries size");
    a_top_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (top_reg >= $past(top_reg)))
        else $error("heap top shrank");
endmodule

@@ hw/rtl/ffa_free_cell.sv @@
// One free-region cell: holds one entry, shifts with its neighbors.
// Depends on ffa_pkg.
module ffa_free_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [ffa_pkg::FIDX_W-1:0]  idx,
    input  ffa_pkg::free_entry_t        reset_val,
    input  ffa_pkg::free_ctl_t          ctl,
    input  ffa_pkg::free_entry_t        left_in,
    input  ffa_pkg::free_entry_t        right_in,
    output ffa_pkg::free_entry_t        entry
);
    ffa_pkg::free_entry_t entry_reg, entry_next;

    always_comb begin
        entry_next = entry_reg;
        unique case (ctl.cmd)
            ffa_pkg::FC_INSERT: begin
                if (idx == ctl.pos) entry_next = ctl.data;
                else if (idx > ctl.pos) entry_next = left_in;
            end
            ffa_pkg::FC_REMOVE: begin
                if (idx >= ctl.pos) entry_next = right_in;
            end
            ffa_pkg::FC_WRITE: begin
                if (idx == ctl.pos) entry_next = ctl.data;
            end
            default: entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) entry_reg <= reset_val;
        else entry_reg <= entry_next;
    end

    assign entry = entry_reg;
endmodule

@@ hw/rtl/ffa_block_cell.sv @@
// One block-table cell: name, start and length of a live block.
// Depends on ffa_pkg.
module ffa_block_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [ffa_pkg::BIDX_W-1:0]  idx,
    input  ffa_pkg::block_ctl_t         ctl,
    input  ffa_pkg::block_entry_t       right_in,
    output ffa_pkg::block_entry_t       entry
);
    logic                          valid_reg, valid_next;
    logic [ffa_pkg::KEY_W-1:0]     name_reg, name_next;
    logic [ffa_pkg::ADDR_W-1:0]    start_reg, start_next;
    logic [ffa_pkg::LEN_W-1:0]     length_reg, length_next;

    always_comb begin
        valid_next  = valid_reg;
        name_next   = name_reg;
        start_next  = start_reg;
        length_next = length_reg;
        if (ctl.append && idx == ctl.pos) begin
            valid_next  = 1'b1;
            name_next   = ctl.data.name;
            start_next  = ctl.data.start;
            length_next = ctl.data.length;
        end else if (ctl.remove && idx >= ctl.pos) begin
            // shift down from the right neighbor
            valid_next  = right_in.valid;
            name_next   = right_in.name;
            start_next  = right_in.start;
            length_next = right_in.length;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else valid_reg <= valid_next;
    end

    always_ff @(posedge aclk) begin
        name_reg   <= name_next;
        start_reg  <= start_next;
        length_reg <= length_next;
    end

    assign entry = '{valid: valid_reg, name: name_reg, start: start_reg, length: length_reg};
endmodule

@@ test/testbench.sv @@
// Testbench for first_fit_named_heap_allocator_unit: directed and random alloc/free traffic
// checked against an allocator model held in a scoreboard class.
// Depends on ffa_pkg and the allocator RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        ffa_pkg::status_t                status;
        logic [ffa_pkg::ADDR_W-1:0]      addr;
        logic [ffa_pkg::LEN_W-1:0]       bytes;
    } alloc_reply_t;

    class heap_scoreboard;
        logic [ffa_pkg::ADDR_W-1:0] fr_start[ffa_pkg::FREE_ENTRIES];
        logic [ffa_pkg::LEN_W-1:0]  fr_len[ffa_pkg::FREE_ENTRIES];
        bit                         fr_ok[ffa_pkg::FREE_ENTRIES];
        logic [ffa_pkg::KEY_W-1:0]  blk_key[ffa_pkg::BLOCK_ENTRIES];
        logic [ffa_pkg::ADDR_W-1:0] blk_start[ffa_pkg::BLOCK_ENTRIES];
        logic [ffa_pkg::LEN_W-1:0]  blk_len[ffa_pkg::BLOCK_ENTRIES];
        bit                         blk_ok[ffa_pkg::BLOCK_ENTRIES];
        logic [ffa_pkg::LEN_W-1:0]  top;
        logic [ffa_pkg::LEN_W-1:0]  ceiling;
        alloc_reply_t               pending[$];
        int                         errors;
        int                         checked;
        int                         status_seen[4];

        function new();
            for (int i = 0; i < ffa_pkg::FREE_ENTRIES; i++) begin
                fr_start[i] = '0; fr_len[i] = '0; fr_ok[i] = 0;
            end
            for (int i = 0; i < ffa_pkg::BLOCK_ENTRIES; i++) blk_ok[i] = 0;
            for (int i = 0; i < 4; i++) status_seen[i] = 0;
            fr_len[0] = ffa_pkg::INIT_TOP;
            fr_ok[0] = 1;
            top = ffa_pkg::INIT_TOP;
            ceiling = ffa_pkg::RESET_CEILING;
            errors = 0;
            checked = 0;
        endfunction

        function int free_used();
            int n;
            n = 0;
            while (n < ffa_pkg::FREE_ENTRIES && fr_ok[n]) n++;
            return n;
        endfunction

        function int blocks_used();
            int n;
            n = 0;
            while (n < ffa_pkg::BLOCK_ENTRIES && blk_ok[n]) n++;
            return n;
        endfunction

        function void region_drop(int idx, int n);
            for (int i = idx; i + 1 < n; i++) begin
                fr_start[i] = fr_start[i+1];
                fr_len[i] = fr_len[i+1];
            end
            fr_start[n-1] = '0;
            fr_len[n-1] = '0;
            fr_ok[n-1] = 0;
        endfunction

        // merge a returned region into the address-ordered free list
        function bit region_return(int s, int l);
            int n, p;
            bit lft, rgt;
            n = free_used();
            p = 0;
            while (p < n && int'(fr_start[p]) <= s) p++;
            lft = (p > 0) && (int'(fr_start[p-1]) + int'(fr_len[p-1]) == s);
            rgt = (p < n) && (s + l == int'(fr_start[p]));
            if (lft && rgt) begin
                fr_len[p-1] = ffa_pkg::LEN_W'(int'(fr_len[p-1]) + l + int'(fr_len[p]));
                region_drop(p, n);
            end else if (lft) begin
                fr_len[p-1] = ffa_pkg::LEN_W'(int'(fr_len[p-1]) + l);
            end else if (rgt) begin
                fr_start[p] = ffa_pkg::ADDR_W'(s);
                fr_len[p] = ffa_pkg::LEN_W'(int'(fr_len[p]) + l);
            end else begin
                if (n >= ffa_pkg::FREE_ENTRIES) return 0;
                for (int i = n; i > p; i--) begin
                    fr_start[i] = fr_start[i-1];
                    fr_len[i] = fr_len[i-1];
                end
                fr_start[p] = ffa_pkg::ADDR_W'(s);
                fr_len[p] = ffa_pkg::LEN_W'(l);
                fr_ok[n] = 1;
            end
            return 1;
        endfunction

        function int first_region(int req);
            int n;
            n = free_used();
            for (int i = 0; i < n; i++)
                if (int'(fr_len[i]) >= req) return i;
            return -1;
        endfunction

        function void note_request(ffa_pkg::op_t op, logic [ffa_pkg::KEY_W-1:0] key,
                                   logic [8:0] pay);
            alloc_reply_t r;
            int lim, req, nb, f, b;
            lim = (int'(ceiling) < ffa_pkg::HEAP_BYTES) ? int'(ceiling) : ffa_pkg::HEAP_BYTES;
            r.status = ffa_pkg::ST_OK;
            r.addr = '0;
            r.bytes = '0;
            nb = blocks_used();
            if (op == ffa_pkg::OP_ALLOC) begin
                req = int'(pay) + 4;
                if (int'(top) >= lim) begin
                    r.status = ffa_pkg::ST_HEAP_FULL;
                end else if (nb >= ffa_pkg::BLOCK_ENTRIES) begin
                    r.status = ffa_pkg::ST_TABLE_FULL;
                end else begin
                    f = first_region(req);
                    if (f < 0) begin
                        if (int'(top) + req >= lim) r.status = ffa_pkg::ST_HEAP_FULL;
                        else if (!region_return(int'(top), req)) r.status = ffa_pkg::ST_TABLE_FULL;
                        else begin
                            top = ffa_pkg::LEN_W'(int'(top) + req);
                            f = first_region(req);
                        end
                    end
                    if (r.status == ffa_pkg::ST_OK && f >= 0) begin
                        r.addr = fr_start[f];
                        r.bytes = ffa_pkg::LEN_W'(req);
                        fr_start[f] = ffa_pkg::ADDR_W'(int'(fr_start[f]) + req);
                        fr_len[f] = ffa_pkg::LEN_W'(int'(fr_len[f]) - req);
                        if (fr_len[f] == '0) region_drop(f, free_used());
                        blk_key[nb] = key;
                        blk_start[nb] = r.addr;
                        blk_len[nb] = ffa_pkg::LEN_W'(req);
                        blk_ok[nb] = 1;
                    end else if (r.status == ffa_pkg::ST_OK) begin
                        r.status = ffa_pkg::ST_HEAP_FULL;
                    end
                end
            end else begin
                b = 0;
                while (b < nb && blk_key[b] != key) b++;
                if (b >= nb) begin
                    r.status = ffa_pkg::ST_NOT_FOUND;
                end else if (!region_return(int'(blk_start[b]), int'(blk_len[b]))) begin
                    r.status = ffa_pkg::ST_TABLE_FULL;
                end else begin
                    r.addr = blk_start[b];
                    r.bytes = blk_len[b];
                    for (int i = b; i + 1 < nb; i++) begin
                        blk_key[i] = blk_key[i+1];
                        blk_start[i] = blk_start[i+1];
                        blk_len[i] = blk_len[i+1];
                    end
                    blk_ok[nb-1] = 0;
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [8:0] addr, logic [9:0] bytes);
            alloc_reply_t e;
            checked++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result status=%0d addr=%0d bytes=%0d",
                         $time, st, addr, bytes);
                errors++;
                return;
            end
            e = pending.pop_front();
            status_seen[st]++;
            if (st !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (addr !== e.addr) begin
                $display("%0t: block_address expected %0d actual %0d", $time, e.addr, addr);
                errors++;
            end
            if (bytes !== e.bytes) begin
                $display("%0t: block_bytes expected %0d actual %0d", $time, e.bytes, bytes);
                errors++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 1000000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [9:0]  cfg_wdata = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic        s_opcode = 0;
    logic [63:0] s_buffer_key = 0;
    logic [8:0]  s_payload_bytes = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [1:0]  m_status;
    logic [8:0]  m_block_address;
    logic [9:0]  m_block_bytes;

    heap_scoreboard sb = new();
    bit  quiet = 0;
    bit  long_hold = 0;
    int  cycles = 0;
    logic [63:0] names[8];

    first_fit_named_heap_allocator_unit u_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_buffer_key(s_buffer_key), .s_payload_bytes(s_payload_bytes),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_block_address(m_block_address), .m_block_bytes(m_block_bytes)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: check, then pick ready for the next cycle
    initial begin
        int idle, hold;
        idle = 0;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_status, m_block_address, m_block_bytes);
            if (long_hold && hold == 0) hold = 300;
            if (hold > 0) begin
                hold--;
                if (hold == 0) long_hold = 0;
                m_ready <= 0;
            end else if (idle > 0) begin
                idle--;
                m_ready <= 0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                idle = $urandom_range(0, 2);
                m_ready <= 0;
            end else begin
                m_ready <= 1;
            end
        end
    end

    task automatic send(ffa_pkg::op_t op, logic [63:0] key, logic [8:0] pay);
        int gap;
        gap = quiet ? 0 : (($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_opcode <= op;
        s_buffer_key <= key;
        s_payload_bytes <= pay;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(op, key, pay);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_ceiling(logic [9:0] v);
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
        sb.ceiling = v;
    endtask

    task automatic random_phase(int count);
        logic [63:0] key;
        logic [8:0]  pay;
        for (int i = 0; i < count; i++) begin
            key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : names[$urandom_range(0, 7)];
            case ($urandom_range(0, 9))
                0:       pay = 9'($urandom);
                1, 2:    pay = 9'($urandom_range(0, 120));
                default: pay = 9'($urandom_range(0, 24));
            endcase
            send(ffa_pkg::op_t'($urandom_range(0, 1)), key, pay);
        end
    endtask

    initial begin
        for (int i = 0; i < 8; i++) names[i] = {$urandom, $urandom};
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        write_ceiling(ffa_pkg::RESET_CEILING);

        // directed: size extremes, unknown name, duplicates, block table full
        send(ffa_pkg::OP_ALLOC, "A", 9'd0);
        send(ffa_pkg::OP_ALLOC, "B", 9'd511);
        send(ffa_pkg::OP_FREE, "nobody", 9'd0);
        send(ffa_pkg::OP_ALLOC, "A", 9'd10);
        send(ffa_pkg::OP_FREE, "A", 9'd0);
        send(ffa_pkg::OP_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, 9'd96);
        send(ffa_pkg::OP_ALLOC, 64'h0, 9'd150);
        for (int i = 0; i < 14; i++) send(ffa_pkg::OP_ALLOC, names[i % 8], 9'd2);
        send(ffa_pkg::OP_FREE, 64'hFFFF_FFFF_FFFF_FFFF, 9'h1FF);
        send(ffa_pkg::OP_FREE, "A", 9'd0);
        send(ffa_pkg::OP_FREE, 64'h0, 9'd0);
        drain();

        // heap already at or past the ceiling
        write_ceiling(10'd0);
        send(ffa_pkg::OP_ALLOC, "Z", 9'd1);
        send(ffa_pkg::OP_FREE, names[0], 9'd0);
        random_phase(150);
        drain();

        write_ceiling(10'd512);
        long_hold = 1;
        random_phase(600);
        drain();

        write_ceiling(10'd200);
        random_phase(500);
        drain();

        write_ceiling(10'd300);
        random_phase(400);
        quiet = 1;
        random_phase(220);
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("Checked %0d results: ok %0d, heap full %0d, not found %0d, table full %0d",
                 sb.checked, sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
                 sb.status_seen[3]);
        $display("Ceilings 300, 0, 512, 200 and 300 were exercised with random idling.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
